// ===== rtl/srcc_pkg.sv =====
package srcc_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int MEM_WORDS_DEF   = 32768;

    localparam logic [15:0] NOT_MASK = 16'h7FFF;

    localparam logic [2:0] F_NONE    = 3'd0;
    localparam logic [2:0] F_OPERAND = 3'd1;
    localparam logic [2:0] F_EMPTY   = 3'd2;
    localparam logic [2:0] F_OPCODE  = 3'd3;
    localparam logic [2:0] F_FULL    = 3'd4;
    localparam logic [2:0] F_DIVZERO = 3'd5;

    localparam logic [4:0] OP_HALT = 5'd0;
    localparam logic [4:0] OP_SET  = 5'd1;
    localparam logic [4:0] OP_PUSH = 5'd2;
    localparam logic [4:0] OP_POP  = 5'd3;
    localparam logic [4:0] OP_EQ   = 5'd4;
    localparam logic [4:0] OP_GT   = 5'd5;
    localparam logic [4:0] OP_JMP  = 5'd6;
    localparam logic [4:0] OP_JT   = 5'd7;
    localparam logic [4:0] OP_JF   = 5'd8;
    localparam logic [4:0] OP_ADD  = 5'd9;
    localparam logic [4:0] OP_MULT = 5'd10;
    localparam logic [4:0] OP_MOD  = 5'd11;
    localparam logic [4:0] OP_AND  = 5'd12;
    localparam logic [4:0] OP_OR   = 5'd13;
    localparam logic [4:0] OP_NOT  = 5'd14;
    localparam logic [4:0] OP_RMEM = 5'd15;
    localparam logic [4:0] OP_WMEM = 5'd16;
    localparam logic [4:0] OP_CALL = 5'd17;
    localparam logic [4:0] OP_RET  = 5'd18;
    localparam logic [4:0] OP_OUT  = 5'd19;
    localparam logic [4:0] OP_IN   = 5'd20;
    localparam logic [4:0] OP_NOOP = 5'd21;

    typedef struct packed {
        logic        operation;
        logic [14:0] load_address;
        logic [15:0] load_value;
        logic [7:0]  in_char;
    } t_in;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_char;
        logic        input_taken;
        logic        halted;
        logic [2:0]  fault;
        logic [14:0] next_pc;
    } t_out;

    // memory port select
    localparam logic [1:0] MA_PC   = 2'd0; // pc + offset
    localparam logic [1:0] MA_X    = 2'd1; // operand x
    localparam logic [1:0] MA_LOAD = 2'd2;
    localparam logic [1:0] MA_W1   = 2'd3;

    typedef struct packed {
        logic       mem_rd;
        logic [1:0] mem_rd_sel;
        logic [1:0] pc_off;
        logic [1:0] fetch_slot;   // 0 op,1 w1,2 w2,3 w3
        logic       fetch_cap;    // capture mem data into slot
        logic       src_x;        // resolve x from w? (sel)
        logic       src_y;
        logic       x_from_w1;    // else from w2
        logic       y_from_w2;    // else from w3
        logic       rdata_to_r;   // rmem result
        logic       stk_rd;
        logic       div_start;
        logic       alu_cap;
        logic       commit;
        logic       load;
    } t_cmd;

    typedef struct packed {
        logic [4:0]  opcode;
        logic        div_done;
    } t_sts;

endpackage

// ===== rtl/stack_register_cpu_core.sv =====
// Stack register CPU core. One input transaction is either a load (write one
// memory word) or a step (fetch and execute one instruction at pc); every input
// transaction returns exactly one result transaction with the status after it.
// A step's duration is set by the main memory, which has one read port and
// one write port (opcode and three operand words read one per cycle), and for
// a modulo instruction also by the bit-serial remainder unit. One transaction
// is processed at a time. Reading a memory word or stack entry that was never
// written returns undefined data.
module stack_register_cpu_core #(
    parameter int STACK_DEPTH = srcc_pkg::STACK_DEPTH_DEF,
    parameter int MEM_WORDS   = srcc_pkg::MEM_WORDS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  srcc_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output srcc_pkg::t_out  o_out_data
);
    srcc_pkg::t_cmd cmd;
    srcc_pkg::t_sts sts;
    srcc_pkg::t_in  r_item;

    // hold the accepted transaction for the datapath
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_item <= i_in_data;
    end

    srcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_in_data.operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    srcc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .MEM_WORDS   (MEM_WORDS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_out_data)
    );

    // a result is never offered while a new transaction can be taken
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and result overlap");

    // once halted, stays halted until reset
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_data.halted) && $past(i_rst_n) |-> o_out_data.halted)
        else $error("halt cleared");

    // fault code only appears together with halt
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_data.fault != srcc_pkg::F_NONE) |-> o_out_data.halted)
        else $error("fault without halt");
endmodule

// ===== rtl/srcc_datapath.sv =====
module srcc_datapath #(
    parameter int STACK_DEPTH = srcc_pkg::STACK_DEPTH_DEF,
    parameter int MEM_WORDS   = srcc_pkg::MEM_WORDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  srcc_pkg::t_in    i_item,
    input  srcc_pkg::t_cmd   i_cmd,
    output srcc_pkg::t_sts   o_sts,
    output srcc_pkg::t_out   o_res
);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int MAW = $clog2(MEM_WORDS);

    logic [15:0] r_mem [MEM_WORDS];
    logic [15:0] r_stk [STACK_DEPTH];
    logic [15:0] r_regs [8];

    logic [15:0] r_mdata, r_sdata;
    logic [15:0] r_op, r_w1, r_w2, r_w3;
    logic [15:0] r_x, r_y, r_res;
    logic        r_xbad, r_ybad;
    logic [CW-1:0] r_cnt;
    logic [14:0] r_pc;
    logic        r_stop;
    logic [2:0]  r_fault;
    logic        r_ov, r_it;
    logic [7:0]  r_oc;

    // iterative remainder
    logic [15:0] r_rem, r_dq;
    logic [4:0]  r_dcnt;
    logic        r_dbusy;

    logic [MAW-1:0] rd_addr;
    logic [14:0]    pc_plus;

    assign pc_plus = r_pc + 15'(i_cmd.pc_off);

    always_comb begin
        unique case (i_cmd.mem_rd_sel)
            srcc_pkg::MA_PC:   rd_addr = MAW'(pc_plus);
            srcc_pkg::MA_X:    rd_addr = MAW'(r_x[14:0]);
            srcc_pkg::MA_LOAD: rd_addr = MAW'(i_item.load_address);
            default:           rd_addr = MAW'(r_w1[14:0]);
        endcase
    end

    // operand resolution
    function automatic logic src_bad(input logic [15:0] w);
        src_bad = w[15] && (w[14:3] != 12'd0);
    endfunction

    logic [15:0] xw, yw;
    assign xw = i_cmd.x_from_w1 ? r_w1 : r_w2;
    assign yw = i_cmd.y_from_w2 ? r_w2 : r_w3;

    logic [4:0] op5;
    assign op5 = r_op[4:0];
    assign o_sts.opcode     = op5;
    assign o_sts.div_done   = !r_dbusy;

    logic dst_bad;
    assign dst_bad = src_bad(r_w1);

    // compute result and fault at commit
    logic [15:0] alu;
    logic [31:0] prod;
    logic [16:0] sum;
    assign prod = 32'(r_x) * 32'(r_y);
    assign sum  = 17'(r_x) + 17'(r_y);

    always_comb begin
        unique case (op5)
            srcc_pkg::OP_EQ:   alu = 16'(r_x == r_y);
            srcc_pkg::OP_GT:   alu = 16'(r_x > r_y);
            srcc_pkg::OP_ADD:  alu = {1'b0, sum[14:0]};
            srcc_pkg::OP_MULT: alu = {1'b0, prod[14:0]};
            srcc_pkg::OP_AND:  alu = r_x & r_y;
            srcc_pkg::OP_OR:   alu = r_x | r_y;
            srcc_pkg::OP_NOT:  alu = r_x ^ srcc_pkg::NOT_MASK;
            default:           alu = r_x;
        endcase
    end

    logic [2:0]  f;
    logic        wr_dst, push, pop, halt_ok, take_ov, take_it;
    logic [15:0] wval, pushv;
    logic [14:0] npc;
    logic        wmem;

    always_comb begin
        f = srcc_pkg::F_NONE;
        wr_dst = 1'b0; push = 1'b0; pop = 1'b0; halt_ok = 1'b0;
        take_ov = 1'b0; take_it = 1'b0; wmem = 1'b0;
        wval = r_res; pushv = r_x; npc = r_pc;
        if (r_op > 16'd21) begin
            f = srcc_pkg::F_OPCODE;
        end else begin
            unique case (op5)
                srcc_pkg::OP_HALT: halt_ok = 1'b1;
                srcc_pkg::OP_SET, srcc_pkg::OP_NOT, srcc_pkg::OP_RMEM: begin
                    if (dst_bad || r_xbad) f = srcc_pkg::F_OPERAND;
                    else begin wr_dst = 1'b1; npc = r_pc + 15'd3; end
                end
                srcc_pkg::OP_PUSH: begin
                    if (r_xbad) f = srcc_pkg::F_OPERAND;
                    else if (r_cnt == CW'(STACK_DEPTH)) f = srcc_pkg::F_FULL;
                    else begin push = 1'b1; npc = r_pc + 15'd2; end
                end
                srcc_pkg::OP_POP: begin
                    if (dst_bad) f = srcc_pkg::F_OPERAND;
                    else if (r_cnt == '0) f = srcc_pkg::F_EMPTY;
                    else begin
                        pop = 1'b1; wr_dst = 1'b1; wval = r_sdata;
                        npc = r_pc + 15'd2;
                    end
                end
                srcc_pkg::OP_EQ, srcc_pkg::OP_GT, srcc_pkg::OP_ADD, srcc_pkg::OP_MULT,
                srcc_pkg::OP_MOD, srcc_pkg::OP_AND, srcc_pkg::OP_OR: begin
                    if (dst_bad || r_xbad || r_ybad) f = srcc_pkg::F_OPERAND;
                    else if (op5 == srcc_pkg::OP_MOD && r_y == 16'd0)
                        f = srcc_pkg::F_DIVZERO;
                    else begin wr_dst = 1'b1; npc = r_pc + 15'd4; end
                end
                srcc_pkg::OP_JMP: begin
                    if (r_xbad) f = srcc_pkg::F_OPERAND;
                    else npc = r_x[14:0];
                end
                srcc_pkg::OP_JT, srcc_pkg::OP_JF: begin
                    if (r_xbad || r_ybad) f = srcc_pkg::F_OPERAND;
                    else if ((op5 == srcc_pkg::OP_JT) == (r_x != 16'd0)) npc = r_y[14:0];
                    else npc = r_pc + 15'd3;
                end
                srcc_pkg::OP_WMEM: begin
                    if (r_xbad || r_ybad) f = srcc_pkg::F_OPERAND;
                    else begin wmem = 1'b1; npc = r_pc + 15'd3; end
                end
                srcc_pkg::OP_CALL: begin
                    if (r_xbad) f = srcc_pkg::F_OPERAND;
                    else if (r_cnt == CW'(STACK_DEPTH)) f = srcc_pkg::F_FULL;
                    else begin
                        push = 1'b1; pushv = {1'b0, r_pc + 15'd2};
                        npc = r_x[14:0];
                    end
                end
                srcc_pkg::OP_RET: begin
                    if (r_cnt == '0) halt_ok = 1'b1;
                    else begin pop = 1'b1; npc = r_sdata[14:0]; end
                end
                srcc_pkg::OP_OUT: begin
                    if (r_xbad) f = srcc_pkg::F_OPERAND;
                    else begin take_ov = 1'b1; npc = r_pc + 15'd2; end
                end
                srcc_pkg::OP_IN: begin
                    if (dst_bad) f = srcc_pkg::F_OPERAND;
                    else begin
                        take_it = 1'b1; wr_dst = 1'b1;
                        wval = {8'd0, i_item.in_char}; npc = r_pc + 15'd2;
                    end
                end
                default: npc = r_pc + 15'd1;
            endcase
        end
    end

    logic ex;
    assign ex = i_cmd.commit && !r_stop;

    // memory: one write port, one read port
    logic            mem_we;
    logic [MAW-1:0]  mem_wa;
    logic [15:0]     mem_wd;
    always_comb begin
        mem_we = 1'b0; mem_wa = MAW'(i_item.load_address); mem_wd = i_item.load_value;
        if (i_cmd.load) begin
            mem_we = 1'b1;
        end else if (ex && f == srcc_pkg::F_NONE) begin
            if (wmem) begin
                mem_we = 1'b1; mem_wa = MAW'(r_x[14:0]); mem_wd = r_y;
            end else if (wr_dst && !r_w1[15]) begin
                mem_we = 1'b1; mem_wa = MAW'(r_w1[14:0]); mem_wd = wval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (i_cmd.mem_rd) r_mdata <= r_mem[rd_addr];
    end

    logic [SW-1:0] stk_ra;
    assign stk_ra = SW'(r_cnt - CW'(1));
    always_ff @(posedge i_clk) begin
        if (ex && f == srcc_pkg::F_NONE && push) r_stk[SW'(r_cnt)] <= pushv;
        if (i_cmd.stk_rd) r_sdata <= r_stk[stk_ra];
    end

    // operand capture and resolution
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch_cap) begin
            unique case (i_cmd.fetch_slot)
                2'd0:    r_op <= r_mdata;
                2'd1:    r_w1 <= r_mdata;
                2'd2:    r_w2 <= r_mdata;
                default: r_w3 <= r_mdata;
            endcase
        end
        if (i_cmd.src_x) begin
            r_xbad <= src_bad(xw);
            r_x    <= xw[15] ? r_regs[xw[2:0]] : xw;
        end
        if (i_cmd.src_y) begin
            r_ybad <= src_bad(yw);
            r_y    <= yw[15] ? r_regs[yw[2:0]] : yw;
        end
        if (i_cmd.alu_cap) r_res <= (op5 == srcc_pkg::OP_MOD) ? r_rem : alu;
        if (i_cmd.rdata_to_r) r_res <= r_mdata;
    end

    // restoring remainder, one bit per cycle
    logic [16:0] trial;
    assign trial = {r_rem, r_dq[15]} - {1'b0, r_y};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1; r_rem <= '0; r_dq <= r_x; r_dcnt <= 5'd16;
        end else if (r_dbusy) begin
            r_rem  <= trial[16] ? {r_rem[14:0], r_dq[15]} : trial[15:0];
            r_dq   <= {r_dq[14:0], 1'b0};
            r_dcnt <= r_dcnt - 5'd1;
            if (r_dcnt == 5'd1) r_dbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_regs[i] <= '0;
            r_cnt <= '0; r_pc <= '0; r_stop <= 1'b0; r_fault <= srcc_pkg::F_NONE;
            r_ov <= 1'b0; r_it <= 1'b0; r_oc <= '0;
        end else if (i_cmd.load) begin
            r_ov <= 1'b0; r_it <= 1'b0; r_oc <= '0;
        end else if (i_cmd.commit) begin
            r_ov <= 1'b0; r_it <= 1'b0; r_oc <= '0;
            if (!r_stop) begin
                if (f != srcc_pkg::F_NONE) begin
                    r_stop <= 1'b1; r_fault <= f;
                end else if (halt_ok) begin
                    r_stop <= 1'b1;
                end else begin
                    r_pc <= npc;
                    if (wr_dst && r_w1[15]) r_regs[r_w1[2:0]] <= wval;
                    if (push) r_cnt <= r_cnt + CW'(1);
                    if (pop)  r_cnt <= r_cnt - CW'(1);
                    r_ov <= take_ov; r_it <= take_it;
                    if (take_ov) r_oc <= r_x[7:0];
                end
            end
        end
    end

    assign o_res.out_valid   = r_ov;
    assign o_res.out_char    = r_oc;
    assign o_res.input_taken = r_it;
    assign o_res.halted      = r_stop;
    assign o_res.fault       = r_fault;
    assign o_res.next_pc     = r_pc;
endmodule

// ===== rtl/srcc_ctrl.sv =====
module srcc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_operation,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  srcc_pkg::t_sts i_sts,
    output srcc_pkg::t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_F0   = 4'd1; // read op
    localparam logic [3:0] S_F1   = 4'd2; // cap op, read w1
    localparam logic [3:0] S_F2   = 4'd3;
    localparam logic [3:0] S_F3   = 4'd4;
    localparam logic [3:0] S_F4   = 4'd5; // cap w3
    localparam logic [3:0] S_SRC  = 4'd6; // resolve x,y; read stack
    localparam logic [3:0] S_ARG  = 4'd7; // rmem read / div start
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_ALU  = 4'd9;
    localparam logic [3:0] S_COMM = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0] r_st, n_st;
    logic       r_load, n_load;

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = (r_st == S_OUT);

    logic xw1;
    always_comb begin
        unique case (i_sts.opcode)
            srcc_pkg::OP_PUSH, srcc_pkg::OP_JMP, srcc_pkg::OP_JT, srcc_pkg::OP_JF,
            srcc_pkg::OP_WMEM, srcc_pkg::OP_CALL, srcc_pkg::OP_OUT: xw1 = 1'b1;
            default: xw1 = 1'b0;
        endcase
    end

    always_comb begin
        n_st = r_st; n_load = r_load;
        o_cmd = '0;
        o_cmd.x_from_w1 = xw1;
        o_cmd.y_from_w2 = xw1;
        unique case (r_st)
            S_IDLE: if (i_in_valid) begin
                n_load = !i_operation;
                n_st = i_operation ? S_F0 : S_COMM;
            end
            S_F0: begin
                o_cmd.mem_rd = 1'b1; o_cmd.mem_rd_sel = srcc_pkg::MA_PC; o_cmd.pc_off = 2'd0;
                n_st = S_F1;
            end
            S_F1, S_F2, S_F3: begin
                o_cmd.fetch_cap = 1'b1;
                o_cmd.fetch_slot = (r_st == S_F1) ? 2'd0 : (r_st == S_F2) ? 2'd1 : 2'd2;
                o_cmd.mem_rd = 1'b1; o_cmd.mem_rd_sel = srcc_pkg::MA_PC;
                o_cmd.pc_off = (r_st == S_F1) ? 2'd1 : (r_st == S_F2) ? 2'd2 : 2'd3;
                n_st = (r_st == S_F1) ? S_F2 : (r_st == S_F2) ? S_F3 : S_F4;
            end
            S_F4: begin
                o_cmd.fetch_cap = 1'b1; o_cmd.fetch_slot = 2'd3;
                n_st = S_SRC;
            end
            S_SRC: begin
                o_cmd.src_x = 1'b1; o_cmd.src_y = 1'b1; o_cmd.stk_rd = 1'b1;
                n_st = S_ARG;
            end
            S_ARG: begin
                if (i_sts.opcode == srcc_pkg::OP_RMEM) begin
                    o_cmd.mem_rd = 1'b1; o_cmd.mem_rd_sel = srcc_pkg::MA_X;
                end
                if (i_sts.opcode == srcc_pkg::OP_MOD) begin
                    o_cmd.div_start = 1'b1; n_st = S_DIV;
                end else begin
                    n_st = S_ALU;
                end
            end
            S_DIV: if (i_sts.div_done) n_st = S_ALU;
            S_ALU: begin
                if (i_sts.opcode == srcc_pkg::OP_RMEM) o_cmd.rdata_to_r = 1'b1;
                else o_cmd.alu_cap = 1'b1;
                n_st = S_COMM;
            end
            S_COMM: begin
                o_cmd.commit = !r_load; o_cmd.load = r_load;
                n_st = S_OUT;
            end
            S_OUT: if (i_out_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_load <= 1'b0;
        end else begin
            r_st <= n_st; r_load <= n_load;
        end
    end
endmodule
